// ===== hw/rtl/thread_slot_scheduler_assert.svh =====
// Assertion macros for the thread slot scheduler.
// Included by the top level; needs no other file.
`ifndef THREAD_SLOT_SCHEDULER_ASSERT_SVH
`define THREAD_SLOT_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("thread_slot_scheduler: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("thread_slot_scheduler: next-cycle check failed");

`endif

// ===== hw/rtl/tss_pkg.sv =====
// Shared constants, codes and control structs of the thread slot scheduler.
// No dependencies.
`default_nettype none

package tss_pkg;

  localparam int THREADS    = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int LEVELS     = 40;
  localparam int LEVEL_W    = 6;
  localparam int BASE_LEVEL = 20;
  localparam int TICKET_W   = 16;
  localparam int SUM_W      = TICKET_W + SLOT_W;
  localparam int TIME_W     = 48;
  localparam int THR_W      = 24;
  localparam int RND_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 24;
  localparam int THR_RESET  = 10000;

  // Slot states.
  localparam logic [1:0] SLOT_UNUSED  = 2'd0;
  localparam logic [1:0] SLOT_READY   = 2'd1;
  localparam logic [1:0] SLOT_RUNNING = 2'd2;

  // Request kinds.
  localparam logic [1:0] KIND_CREATE   = 2'd0;
  localparam logic [1:0] KIND_SCHEDULE = 2'd1;
  localparam logic [1:0] KIND_EXIT     = 2'd2;

  // Scheduling modes.
  localparam logic [1:0] MODE_RR      = 2'd0;
  localparam logic [1:0] MODE_PRIO    = 2'd1;
  localparam logic [1:0] MODE_LOTTERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_FULL = 2'd1;
  localparam logic [1:0] RES_NONE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THR  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              create;
    logic              ignore;
    logic              exit_rm;
    logic              sched_start;
    logic              rr_pick;
    logic              age;
    logic              pri_level;
    logic              pri_pick;
    logic              lot_acc;
    logic              div_init;
    logic              div_step;
    logic              lot_scan;
    logic              commit;
    logic              emit;
    logic [SLOT_W-1:0] idx;
  } tss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       total_zero;
    logic       out_busy;
  } tss_stat_t;

  // Level of a new thread: priority plus base level, saturated to the level range.
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [LEVEL_W-1:0] p);
    logic signed [LEVEL_W:0] v;
    logic [LEVEL_W-1:0]      r;
    v = $signed({p[LEVEL_W-1], p}) + $signed((LEVEL_W+1)'(BASE_LEVEL));
    if (v < $signed((LEVEL_W+1)'(0))) begin
      r = '0;
    end else if (v > $signed((LEVEL_W+1)'(LEVELS - 1))) begin
      r = LEVEL_W'(LEVELS - 1);
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tss_req_if.sv =====
// Request channel of the thread slot scheduler: valid, ready and request fields.
// Depends on tss_pkg.
`default_nettype none

interface tss_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic signed [tss_pkg::LEVEL_W-1:0]   create_priority;
  logic [tss_pkg::TICKET_W-1:0]         create_tickets;
  logic [tss_pkg::TIME_W-1:0]           now_us;
  logic [tss_pkg::RND_W-1:0]            random_value;

  modport source (output valid, kind, create_priority, create_tickets, now_us, random_value,
                  input ready);
  modport sink (input valid, kind, create_priority, create_tickets, now_us, random_value,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tss_rsp_if.sv =====
// Result channel of the thread slot scheduler: valid, ready and result fields.
// Depends on tss_pkg.
`default_nettype none

interface tss_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic                         switched;
  logic [tss_pkg::SLOT_W-1:0]   prev_thread;
  logic [tss_pkg::SLOT_W-1:0]   next_thread;
  logic [tss_pkg::SLOT_W-1:0]   new_slot;

  modport source (output valid, status, switched, prev_thread, next_thread, new_slot,
                  input ready);
  modport sink (input valid, status, switched, prev_thread, next_thread, new_slot,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tss_ctrl.sv =====
// Controller state machine of the thread slot scheduler.
// Depends on tss_pkg; drives the datapath through tss_cmd_t.
`default_nettype none

module tss_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire tss_pkg::tss_stat_t stat_i,
  output tss_pkg::tss_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_EXIT     = 4'd2;
  localparam logic [3:0] S_SCHED    = 4'd3;
  localparam logic [3:0] S_AGE      = 4'd4;
  localparam logic [3:0] S_PLVL     = 4'd5;
  localparam logic [3:0] S_PPICK    = 4'd6;
  localparam logic [3:0] S_LSUM     = 4'd7;
  localparam logic [3:0] S_LINIT    = 4'd8;
  localparam logic [3:0] S_LDIV     = 4'd9;
  localparam logic [3:0] S_LSCAN    = 4'd10;
  localparam logic [3:0] S_COMMIT   = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam int DIV_STEPS = tss_pkg::RND_W;
  localparam int CTR_W     = $clog2(DIV_STEPS);

  logic [3:0]       state_q, state_d;
  logic [CTR_W-1:0] cnt_q, cnt_d;

  // Next state, loop counter and commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q[tss_pkg::SLOT_W-1:0];
    req_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.kind)
          tss_pkg::KIND_CREATE: begin
            cmd_o.create = 1'b1;
            state_d      = S_DONE;
          end
          tss_pkg::KIND_SCHEDULE: state_d = S_SCHED;
          tss_pkg::KIND_EXIT:     state_d = S_EXIT;
          default: begin
            cmd_o.ignore = 1'b1;
            state_d      = S_DONE;
          end
        endcase
      end
      S_EXIT: begin
        cmd_o.exit_rm = 1'b1;
        state_d       = S_SCHED;
      end
      S_SCHED: begin
        cmd_o.sched_start = 1'b1;
        cnt_d             = '0;
        case (stat_i.mode)
          tss_pkg::MODE_PRIO:    state_d = S_AGE;
          tss_pkg::MODE_LOTTERY: state_d = S_LSUM;
          default:               state_d = S_DISPATCH;
        endcase
        if (stat_i.mode != tss_pkg::MODE_PRIO && stat_i.mode != tss_pkg::MODE_LOTTERY) begin
          state_d = S_COMMIT;
        end
      end
      S_AGE: begin
        cmd_o.age = 1'b1;
        cnt_d     = cnt_q + CTR_W'(1);
        if (cnt_q == CTR_W'(tss_pkg::THREADS - 1)) begin
          state_d = S_PLVL;
        end
      end
      S_PLVL: begin
        cmd_o.pri_level = 1'b1;
        state_d         = S_PPICK;
      end
      S_PPICK: begin
        cmd_o.pri_pick = 1'b1;
        state_d        = S_COMMIT;
      end
      S_LSUM: begin
        cmd_o.lot_acc = 1'b1;
        cnt_d         = cnt_q + CTR_W'(1);
        if (cnt_q == CTR_W'(tss_pkg::THREADS - 1)) begin
          cnt_d   = '0;
          state_d = S_LINIT;
        end
      end
      S_LINIT: begin
        if (stat_i.total_zero) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_LDIV;
        end
      end
      S_LDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CTR_W'(1);
        if (cnt_q == CTR_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_LSCAN;
        end
      end
      S_LSCAN: begin
        cmd_o.lot_scan = 1'b1;
        cnt_d          = cnt_q + CTR_W'(1);
        if (cnt_q == CTR_W'(tss_pkg::THREADS - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_SCHED && stat_i.mode != tss_pkg::MODE_PRIO &&
        stat_i.mode != tss_pkg::MODE_LOTTERY) begin
      cmd_o.rr_pick = 1'b1;
    end
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_dp.sv =====
// Datapath of the thread slot scheduler: slot table, queue ranks, lottery divider,
// configuration and result registers. Depends on tss_pkg; driven by tss_ctrl.
`default_nettype none

module tss_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tss_pkg::tss_cmd_t                   cmd_i,
  output tss_pkg::tss_stat_t                       stat_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tss_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic [1:0]                          req_kind_i,
  input  wire logic signed [tss_pkg::LEVEL_W-1:0]  req_prio_i,
  input  wire logic [tss_pkg::TICKET_W-1:0]        req_tickets_i,
  input  wire logic [tss_pkg::TIME_W-1:0]          req_now_i,
  input  wire logic [tss_pkg::RND_W-1:0]           req_rnd_i,
  input  wire logic                                rsp_ready_i,
  output logic                                     rsp_valid_o,
  output logic [1:0]                               rsp_status_o,
  output logic                                     rsp_switched_o,
  output logic [tss_pkg::SLOT_W-1:0]               rsp_prev_o,
  output logic [tss_pkg::SLOT_W-1:0]               rsp_next_o,
  output logic [tss_pkg::SLOT_W-1:0]               rsp_new_o
);

  localparam int N  = tss_pkg::THREADS;
  localparam int SW = tss_pkg::SLOT_W;
  localparam int LW = tss_pkg::LEVEL_W;
  localparam int CW = tss_pkg::CNT_W;
  localparam int UW = tss_pkg::SUM_W;

  // Slot table; rank is the position of a slot in the queue of its level.
  logic [1:0]                   status_q  [N];
  logic [LW-1:0]                level_q   [N];
  logic [SW-1:0]                rank_q    [N];
  logic [tss_pkg::TICKET_W-1:0] tickets_q [N];
  logic [tss_pkg::TIME_W-1:0]   started_q [N];
  logic [SW-1:0]                running_q;

  // Configuration.
  logic [1:0]                   mode_q;
  logic [tss_pkg::THR_W-1:0]    thr_q;

  // Request copy.
  logic [1:0]                   kind_q;
  logic signed [LW-1:0]         prio_q;
  logic [tss_pkg::TICKET_W-1:0] tick_q;
  logic [tss_pkg::TIME_W-1:0]   now_q;
  logic [SW-1:0]                prev_q;

  // Scheduling work registers.
  logic [SW-1:0]                pick_q;
  logic                         pick_vld_q;
  logic [LW-1:0]                best_q;
  logic                         best_vld_q;
  logic [UW-1:0]                total_q;
  logic [UW-1:0]                sum_q;
  logic [UW-1:0]                rem_q;
  logic [tss_pkg::RND_W-1:0]    dvd_q;

  // Result and output registers.
  logic [1:0]                   res_status_q;
  logic                         res_sw_q;
  logic [SW-1:0]                res_next_q;
  logic [SW-1:0]                res_new_q;
  logic                         out_vld_q;
  logic [1:0]                   out_status_q;
  logic                         out_sw_q;
  logic [SW-1:0]                out_prev_q;
  logic [SW-1:0]                out_next_q;
  logic [SW-1:0]                out_new_q;

  logic                         out_busy;
  assign out_busy = out_vld_q && !rsp_ready_i;

  assign stat_o.kind       = kind_q;
  assign stat_o.mode       = mode_q;
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.out_busy   = out_busy;

  assign rsp_valid_o    = out_vld_q;
  assign rsp_status_o   = out_status_q;
  assign rsp_switched_o = out_sw_q;
  assign rsp_prev_o     = out_prev_q;
  assign rsp_next_o     = out_next_q;
  assign rsp_new_o      = out_new_q;

  // Create: first unused slot, its level and its place at the tail of that queue.
  logic          free_vld;
  logic [SW-1:0] free_slot;
  logic [LW-1:0] new_level;
  logic [CW-1:0] new_rank;
  always_comb begin
    free_vld  = 1'b0;
    free_slot = '0;
    new_level = tss_pkg::clamp_level(prio_q);
    new_rank  = '0;
    for (int j = N - 1; j >= 0; j--) begin
      if (status_q[j] == tss_pkg::SLOT_UNUSED) begin
        free_vld  = 1'b1;
        free_slot = SW'(j);
      end
    end
    for (int j = 0; j < N; j++) begin
      if (status_q[j] != tss_pkg::SLOT_UNUSED && level_q[j] == new_level) begin
        new_rank = new_rank + CW'(1);
      end
    end
  end

  // Exit: the running slot leaves its queue unless it is slot 0 or already unused.
  logic rm_ok;
  assign rm_ok = (running_q != '0) && (status_q[running_q] != tss_pkg::SLOT_UNUSED);

  // Aging of one slot: wait against threshold, and its tail place one level up.
  logic [tss_pkg::TIME_W-1:0] age_wait;
  logic                       age_hit;
  logic [LW-1:0]              age_lvl;
  logic [CW-1:0]              age_rank;
  always_comb begin
    age_wait = now_q - started_q[cmd_i.idx];
    age_lvl  = level_q[cmd_i.idx] - LW'(1);
    age_hit  = (status_q[cmd_i.idx] == tss_pkg::SLOT_READY) && (cmd_i.idx != running_q) &&
               (age_wait >= tss_pkg::TIME_W'(thr_q)) && (level_q[cmd_i.idx] != '0);
    age_rank = '0;
    for (int j = 0; j < N; j++) begin
      if (SW'(j) != cmd_i.idx && status_q[j] != tss_pkg::SLOT_UNUSED &&
          level_q[j] == age_lvl) begin
        age_rank = age_rank + CW'(1);
      end
    end
  end

  // Priority: best level holding a ready slot.
  logic [LW-1:0] lvl_min;
  logic          lvl_vld;
  always_comb begin
    lvl_min = '0;
    lvl_vld = 1'b0;
    for (int j = 0; j < N; j++) begin
      if (status_q[j] == tss_pkg::SLOT_READY && (!lvl_vld || level_q[j] < lvl_min)) begin
        lvl_min = level_q[j];
        lvl_vld = 1'b1;
      end
    end
  end

  // Priority: last ready slot of the best queue, and the queue length.
  logic [SW-1:0] pp_slot;
  logic [SW-1:0] pp_rank;
  logic          pp_vld;
  logic [CW-1:0] pp_len;
  always_comb begin
    pp_slot = '0;
    pp_rank = '0;
    pp_vld  = 1'b0;
    pp_len  = '0;
    for (int j = 0; j < N; j++) begin
      if (status_q[j] != tss_pkg::SLOT_UNUSED && level_q[j] == best_q) begin
        pp_len = pp_len + CW'(1);
      end
      if (status_q[j] == tss_pkg::SLOT_READY && level_q[j] == best_q &&
          (!pp_vld || rank_q[j] > pp_rank)) begin
        pp_slot = SW'(j);
        pp_rank = rank_q[j];
        pp_vld  = 1'b1;
      end
    end
  end

  // Round robin: first ready slot from the running slot onward.
  logic [SW-1:0] rr_slot;
  logic          rr_vld;
  always_comb begin
    logic [SW-1:0] p;
    rr_slot = '0;
    rr_vld  = 1'b0;
    for (int k = 0; k < N; k++) begin
      p = running_q + SW'(k);
      if (!rr_vld && status_q[p] == tss_pkg::SLOT_READY) begin
        rr_slot = p;
        rr_vld  = 1'b1;
      end
    end
  end

  // Lottery: one divider step and one scan step.
  logic [UW:0]   div_sh;
  logic [UW-1:0] scan_sum;
  assign div_sh   = {rem_q, dvd_q[tss_pkg::RND_W-1]};
  assign scan_sum = sum_q + UW'(tickets_q[cmd_i.idx]);

  logic do_switch;
  assign do_switch = pick_vld_q && (pick_q != running_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tss_pkg::MODE_RR;
      thr_q  <= tss_pkg::THR_W'(tss_pkg::THR_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tss_pkg::REG_MODE: mode_q <= cfg_wdata_i[1:0];
        tss_pkg::REG_THR:  thr_q  <= cfg_wdata_i[tss_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot table updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) begin
        status_q[j]  <= tss_pkg::SLOT_UNUSED;
        level_q[j]   <= LW'(tss_pkg::BASE_LEVEL);
        rank_q[j]    <= '0;
        tickets_q[j] <= '0;
        started_q[j] <= '0;
      end
      status_q[0] <= tss_pkg::SLOT_RUNNING;
      running_q   <= '0;
    end else begin
      if (cmd_i.create && free_vld) begin
        status_q[free_slot]  <= tss_pkg::SLOT_READY;
        level_q[free_slot]   <= new_level;
        rank_q[free_slot]    <= new_rank[SW-1:0];
        tickets_q[free_slot] <= tick_q;
      end
      if (cmd_i.exit_rm && rm_ok) begin
        for (int j = 0; j < N; j++) begin
          if (status_q[j] != tss_pkg::SLOT_UNUSED && level_q[j] == level_q[running_q] &&
              rank_q[j] > rank_q[running_q]) begin
            rank_q[j] <= rank_q[j] - SW'(1);
          end
        end
        status_q[running_q] <= tss_pkg::SLOT_UNUSED;
      end
      if (cmd_i.age && age_hit) begin
        for (int j = 0; j < N; j++) begin
          if (status_q[j] != tss_pkg::SLOT_UNUSED && level_q[j] == level_q[cmd_i.idx] &&
              rank_q[j] > rank_q[cmd_i.idx]) begin
            rank_q[j] <= rank_q[j] - SW'(1);
          end
        end
        level_q[cmd_i.idx]   <= age_lvl;
        rank_q[cmd_i.idx]    <= age_rank[SW-1:0];
        started_q[cmd_i.idx] <= now_q;
      end
      // Rotate the best queue left by one: the head moves to the tail.
      if (cmd_i.pri_pick && best_vld_q) begin
        for (int j = 0; j < N; j++) begin
          if (status_q[j] != tss_pkg::SLOT_UNUSED && level_q[j] == best_q) begin
            if (rank_q[j] == '0) begin
              rank_q[j] <= SW'(pp_len - CW'(1));
            end else begin
              rank_q[j] <= rank_q[j] - SW'(1);
            end
          end
        end
      end
      if (cmd_i.commit && do_switch) begin
        if (status_q[running_q] != tss_pkg::SLOT_UNUSED) begin
          status_q[running_q] <= tss_pkg::SLOT_READY;
        end
        status_q[pick_q]  <= tss_pkg::SLOT_RUNNING;
        started_q[pick_q] <= now_q;
        running_q         <= pick_q;
      end
    end
  end

  // Request copy, pick and lottery registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_kind_i;
      prio_q <= req_prio_i;
      tick_q <= req_tickets_i;
      now_q  <= req_now_i;
      dvd_q  <= req_rnd_i;
      prev_q <= running_q;
    end
    if (cmd_i.sched_start) begin
      pick_vld_q <= 1'b0;
      total_q    <= '0;
      sum_q      <= '0;
    end
    if (cmd_i.rr_pick) begin
      pick_q     <= rr_slot;
      pick_vld_q <= rr_vld;
    end
    if (cmd_i.pri_level) begin
      best_q     <= lvl_min;
      best_vld_q <= lvl_vld;
    end
    if (cmd_i.pri_pick) begin
      pick_q     <= pp_slot;
      pick_vld_q <= best_vld_q && pp_vld;
    end
    if (cmd_i.lot_acc && status_q[cmd_i.idx] == tss_pkg::SLOT_READY) begin
      total_q <= total_q + UW'(tickets_q[cmd_i.idx]);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
    end
    // Restoring division: one quotient bit per step, only the remainder is kept.
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[tss_pkg::RND_W-2:0], 1'b0};
      if (div_sh >= {1'b0, total_q}) begin
        rem_q <= UW'(div_sh - {1'b0, total_q});
      end else begin
        rem_q <= div_sh[UW-1:0];
      end
    end
    if (cmd_i.lot_scan && status_q[cmd_i.idx] == tss_pkg::SLOT_READY) begin
      sum_q <= scan_sum;
      if (!pick_vld_q && scan_sum > rem_q) begin
        pick_q     <= cmd_i.idx;
        pick_vld_q <= 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      res_status_q <= free_vld ? tss_pkg::RES_OK : tss_pkg::RES_FULL;
      res_sw_q     <= 1'b0;
      res_next_q   <= running_q;
      res_new_q    <= free_vld ? free_slot : '0;
    end
    if (cmd_i.ignore) begin
      res_status_q <= tss_pkg::RES_OK;
      res_sw_q     <= 1'b0;
      res_next_q   <= running_q;
      res_new_q    <= '0;
    end
    if (cmd_i.commit) begin
      res_status_q <= do_switch ? tss_pkg::RES_OK : tss_pkg::RES_NONE;
      res_sw_q     <= do_switch;
      res_next_q   <= do_switch ? pick_q : running_q;
      res_new_q    <= '0;
    end
  end

  // Output register, freed when the consumer takes the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_sw_q     <= res_sw_q;
      out_prev_q   <= prev_q;
      out_next_q   <= res_next_q;
      out_new_q    <= res_new_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/thread_slot_scheduler.sv =====
// Top level of the thread slot scheduler: controller plus datapath.
// Depends on tss_pkg, tss_req_if, tss_rsp_if, tss_ctrl, tss_dp and the assertion header.
//
//   Channel   Direction  Handshake          Carries
//   req_i     in         valid / ready      kind, priority, tickets, time, random draw
//   rsp_o     out        valid / ready      status, switched, prev, next, new slot
//   cfg       in         cfg_we_i only      sched_mode, aging_threshold
//
// One request at a time. Create and ignored kinds pass dispatch and done; round robin
// adds schedule and commit, an exit one state more, priority eight aging steps, one per
// slot, level and pick, lottery eight sums, a 32-step restoring divider and eight scans.
// A new request is taken while the previous result still waits in the output register.
// Reset is asynchronous and active low; no clearing pass follows it.
`default_nettype none
`include "thread_slot_scheduler_assert.svh"

module thread_slot_scheduler (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tss_req_if.sink                                req_i,
  tss_rsp_if.source                              rsp_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tss_pkg::CFG_W-1:0]         cfg_wdata_i
);

  tss_pkg::tss_cmd_t  cmd;
  tss_pkg::tss_stat_t stat;
  logic               req_ready;

  assign req_i.ready = req_ready;

  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_kind_i     (req_i.kind),
    .req_prio_i     (req_i.create_priority),
    .req_tickets_i  (req_i.create_tickets),
    .req_now_i      (req_i.now_us),
    .req_rnd_i      (req_i.random_value),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_status_o   (rsp_o.status),
    .rsp_switched_o (rsp_o.switched),
    .rsp_prev_o     (rsp_o.prev_thread),
    .rsp_next_o     (rsp_o.next_thread),
    .rsp_new_o      (rsp_o.new_slot)
  );

  // An accepted request leaves the idle state at once.
  `TSS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_ready, !req_ready)
  // A switch is only reported with an ok status.
  `TSS_ASSERT_NOW(a_switch_ok, clk_i, rst_ni, rsp_o.valid && rsp_o.switched,
                  rsp_o.status == tss_pkg::RES_OK)
  // Without a ready thread the running slot stays as it was.
  `TSS_ASSERT_NOW(a_none_keeps, clk_i, rst_ni,
                  rsp_o.valid && rsp_o.status == tss_pkg::RES_NONE,
                  rsp_o.next_thread == rsp_o.prev_thread && !rsp_o.switched)

endmodule

`default_nettype wire

// ===== sim/tb_thread_slot_scheduler.sv =====
// Testbench of the thread slot scheduler: directed and random requests in every mode.
// A built-in predictor of the slot table checks each result. Depends on tss_pkg,
// tss_req_if, tss_rsp_if and the thread_slot_scheduler RTL.
`timescale 1ns / 100ps

module tb_thread_slot_scheduler;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic [1:0] MODE_ALT_RR  = 2'd3;
  localparam int         QUIET_LIMIT  = 5000;
  localparam int         HOLD_CYCLES  = 400;

  typedef struct {
    logic [1:0]                         kind;
    logic signed [tss_pkg::LEVEL_W-1:0] prio;
    logic [tss_pkg::TICKET_W-1:0]       tickets;
    logic [tss_pkg::TIME_W-1:0]         now;
    logic [tss_pkg::RND_W-1:0]          rnd;
  } sched_req_t;

  typedef struct {
    logic [1:0]                 status;
    logic                       switched;
    logic [tss_pkg::SLOT_W-1:0] prev;
    logic [tss_pkg::SLOT_W-1:0] next;
    logic [tss_pkg::SLOT_W-1:0] new_slot;
  } sched_rsp_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [tss_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tss_pkg::CFG_W-1:0]     cfg_wdata;

  tss_req_if req ();
  tss_rsp_if rsp ();

  thread_slot_scheduler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the scheduler state.
  logic [1:0]                   m_mode;
  logic [tss_pkg::THR_W-1:0]    m_thr;
  logic [1:0]                   m_stat  [tss_pkg::THREADS];
  int                           m_level [tss_pkg::THREADS];
  logic [tss_pkg::TICKET_W-1:0] m_tix   [tss_pkg::THREADS];
  logic [tss_pkg::TIME_W-1:0]   m_start [tss_pkg::THREADS];
  int                           m_cur;
  int                           m_qent  [tss_pkg::LEVELS][tss_pkg::THREADS];
  int                           m_qcnt  [tss_pkg::LEVELS];

  sched_rsp_t                 expected_q[$];
  int                         errors;
  logic [tss_pkg::TIME_W-1:0] clock_us;
  bit                         idle_on;
  int                         hold_reqs;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Level queue helpers.
  function automatic void queue_push(int lvl, int slot);
    if (m_qcnt[lvl] < tss_pkg::THREADS) begin
      m_qent[lvl][m_qcnt[lvl]] = slot;
      m_qcnt[lvl]++;
    end
  endfunction

  function automatic void queue_drop(int lvl, int slot);
    int n;
    n = m_qcnt[lvl];
    for (int i = 0; i < n; i++) begin
      if (m_qent[lvl][i] == slot) begin
        for (int j = i; j + 1 < n; j++) m_qent[lvl][j] = m_qent[lvl][j + 1];
        m_qcnt[lvl]--;
        return;
      end
    end
  endfunction

  function automatic void table_reset();
    m_mode = tss_pkg::MODE_RR;
    m_thr  = tss_pkg::THR_W'(tss_pkg::THR_RESET);
    for (int i = 0; i < tss_pkg::THREADS; i++) begin
      m_stat[i]  = tss_pkg::SLOT_UNUSED;
      m_level[i] = tss_pkg::BASE_LEVEL;
      m_tix[i]   = '0;
      m_start[i] = '0;
    end
    for (int l = 0; l < tss_pkg::LEVELS; l++) begin
      m_qcnt[l] = 0;
      for (int t = 0; t < tss_pkg::THREADS; t++) m_qent[l][t] = 0;
    end
    m_stat[0] = tss_pkg::SLOT_RUNNING;
    m_cur     = 0;
    queue_push(tss_pkg::BASE_LEVEL, 0);
  endfunction

  function automatic int pick_round_robin();
    int p;
    p = m_cur;
    for (int k = 0; k < tss_pkg::THREADS; k++) begin
      if (m_stat[p] == tss_pkg::SLOT_READY) return p;
      p = (p + 1) % tss_pkg::THREADS;
    end
    return -1;
  endfunction

  // Aging pass, then the last ready entry of the best level; that queue rotates left.
  function automatic int pick_priority(logic [tss_pkg::TIME_W-1:0] now);
    logic [tss_pkg::TIME_W-1:0] waited;
    int found, first, n;
    for (int i = 0; i < tss_pkg::THREADS; i++) begin
      if (m_stat[i] != tss_pkg::SLOT_READY || i == m_cur) continue;
      waited = now - m_start[i];
      if (waited >= tss_pkg::TIME_W'(m_thr) && m_level[i] > 0) begin
        queue_drop(m_level[i], i);
        m_level[i]--;
        queue_push(m_level[i], i);
        m_start[i] = now;
      end
    end
    for (int l = 0; l < tss_pkg::LEVELS; l++) begin
      found = -1;
      n = m_qcnt[l];
      for (int t = 0; t < n; t++)
        if (m_stat[m_qent[l][t]] == tss_pkg::SLOT_READY) found = m_qent[l][t];
      if (found < 0) continue;
      first = m_qent[l][0];
      for (int t = 0; t + 1 < n; t++) m_qent[l][t] = m_qent[l][t + 1];
      m_qent[l][n - 1] = first;
      return found;
    end
    return -1;
  endfunction

  function automatic int pick_lottery(logic [tss_pkg::RND_W-1:0] rnd);
    longint total, acc, draw;
    total = 0;
    acc   = 0;
    for (int i = 0; i < tss_pkg::THREADS; i++)
      if (m_stat[i] == tss_pkg::SLOT_READY) total += m_tix[i];
    if (total == 0) return -1;
    draw = longint'(rnd) % total;
    for (int i = 0; i < tss_pkg::THREADS; i++) begin
      if (m_stat[i] != tss_pkg::SLOT_READY) continue;
      acc += m_tix[i];
      if (acc > draw) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] run_schedule(sched_req_t r, output logic sw);
    int pick;
    sw = 1'b0;
    if (m_mode == tss_pkg::MODE_PRIO) pick = pick_priority(r.now);
    else if (m_mode == tss_pkg::MODE_LOTTERY) pick = pick_lottery(r.rnd);
    else pick = pick_round_robin();
    if (pick < 0 || pick == m_cur) return tss_pkg::RES_NONE;
    if (m_stat[m_cur] != tss_pkg::SLOT_UNUSED) m_stat[m_cur] = tss_pkg::SLOT_READY;
    m_stat[pick]  = tss_pkg::SLOT_RUNNING;
    m_start[pick] = r.now;
    m_cur = pick;
    sw = 1'b1;
    return tss_pkg::RES_OK;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic sched_rsp_t predict_result(sched_req_t r);
    sched_rsp_t res;
    int lvl;
    res = '{status: tss_pkg::RES_OK, switched: 1'b0, prev: tss_pkg::SLOT_W'(m_cur),
            next: '0, new_slot: '0};
    case (r.kind)
      tss_pkg::KIND_CREATE: begin
        res.status = tss_pkg::RES_FULL;
        for (int i = 0; i < tss_pkg::THREADS; i++) begin
          if (m_stat[i] == tss_pkg::SLOT_UNUSED) begin
            lvl = int'(r.prio) + tss_pkg::BASE_LEVEL;
            if (lvl < 0) lvl = 0;
            if (lvl > tss_pkg::LEVELS - 1) lvl = tss_pkg::LEVELS - 1;
            m_stat[i]  = tss_pkg::SLOT_READY;
            m_level[i] = lvl;
            m_tix[i]   = r.tickets;
            queue_push(lvl, i);
            res.new_slot = tss_pkg::SLOT_W'(i);
            res.status   = tss_pkg::RES_OK;
            break;
          end
        end
      end
      tss_pkg::KIND_SCHEDULE: res.status = run_schedule(r, res.switched);
      tss_pkg::KIND_EXIT: begin
        if (m_cur != 0 && m_stat[m_cur] != tss_pkg::SLOT_UNUSED) begin
          queue_drop(m_level[m_cur], m_cur);
          m_stat[m_cur] = tss_pkg::SLOT_UNUSED;
        end
        res.status = run_schedule(r, res.switched);
      end
      default: ;
    endcase
    res.next = tss_pkg::SLOT_W'(m_cur);
    return res;
  endfunction

  // Gap length: none for the given percentage of draws, else mostly short and a few long.
  function automatic int gap_len(int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < none_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls plus the long hold-off on request.
  initial begin
    int hold_left, stall_left, hold_seen;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = gap_len(0);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    sched_rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d next %0d", $time, rsp.status,
                 rsp.next_thread);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("status", e.status, rsp.status);
        check_field("switched", e.switched, rsp.switched);
        check_field("prev_thread", e.prev, rsp.prev_thread);
        check_field("next_thread", e.next, rsp.next_thread);
        check_field("new_slot", e.new_slot, rsp.new_slot);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sends one request and records its expected result once accepted.
  task automatic send_request(sched_req_t r);
    int gap;
    gap = idle_on ? gap_len(70) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid           <= 1'b1;
    req.kind            <= r.kind;
    req.create_priority <= r.prio;
    req.create_tickets  <= r.tickets;
    req.now_us          <= r.now;
    req.random_value    <= r.rnd;
    do @(posedge clk_i); while (!req.ready);
    expected_q.push_back(predict_result(r));
  endtask

  // Free-running time: small steps, some aging-sized jumps, rare random values.
  function automatic logic [tss_pkg::TIME_W-1:0] advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) clock_us += tss_pkg::TIME_W'($urandom_range(0, 3000));
    else if (r < 95) clock_us += tss_pkg::TIME_W'($urandom_range(5000, 30000));
    else clock_us = tss_pkg::TIME_W'({$urandom, $urandom});
    return clock_us;
  endfunction

  task automatic send_fields(logic [1:0] kind, int prio, int tickets,
                             logic [tss_pkg::RND_W-1:0] rnd);
    sched_req_t r;
    r = '{kind: kind, prio: tss_pkg::LEVEL_W'(prio), tickets: tss_pkg::TICKET_W'(tickets),
          now: advance_time(), rnd: rnd};
    send_request(r);
  endtask

  task automatic send_random();
    sched_req_t r;
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) r.kind = tss_pkg::KIND_CREATE;
    else if (k < 75) r.kind = tss_pkg::KIND_SCHEDULE;
    else if (k < 95) r.kind = tss_pkg::KIND_EXIT;
    else r.kind = KIND_IGNORED;
    r.prio = tss_pkg::LEVEL_W'($urandom);
    case ($urandom_range(0, 9))
      0:       r.tickets = '0;
      1:       r.tickets = '1;
      default: r.tickets = tss_pkg::TICKET_W'($urandom);
    endcase
    r.now = advance_time();
    r.rnd = $urandom;
    send_request(r);
  endtask

  // Waits until every result is back, then writes both registers.
  task automatic configure(logic [1:0] mode, logic [tss_pkg::THR_W-1:0] thr);
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= tss_pkg::REG_MODE;
    cfg_wdata <= tss_pkg::CFG_W'(mode);
    @(posedge clk_i);
    cfg_idx   <= tss_pkg::REG_THR;
    cfg_wdata <= thr;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    m_mode = mode;
    m_thr  = thr;
  endtask

  task automatic run_random(int count);
    repeat (count) send_random();
  endtask

  // Ignored kind, empty schedules, full table, priority and ticket extremes, exits.
  task automatic test_directed();
    send_fields(KIND_IGNORED, 0, 0, 0);
    send_fields(tss_pkg::KIND_SCHEDULE, 0, 0, 0);
    send_fields(tss_pkg::KIND_EXIT, 0, 0, 0);
    send_fields(tss_pkg::KIND_CREATE, -32, 0, 0);
    send_fields(tss_pkg::KIND_CREATE, 31, 65535, 0);
    send_fields(tss_pkg::KIND_CREATE, -20, 1, 0);
    send_fields(tss_pkg::KIND_CREATE, 19, 100, 0);
    send_fields(tss_pkg::KIND_CREATE, 0, 7, 0);
    send_fields(tss_pkg::KIND_CREATE, -21, 0, 0);
    send_fields(tss_pkg::KIND_CREATE, 20, 3, 0);
    send_fields(tss_pkg::KIND_CREATE, 5, 5, 0);
    send_fields(tss_pkg::KIND_SCHEDULE, 0, 0, 0);
    repeat (8) send_fields(tss_pkg::KIND_EXIT, 0, 0, 0);
    // Lottery with only zero-ticket threads must not switch.
    configure(tss_pkg::MODE_LOTTERY, tss_pkg::THR_W'(tss_pkg::THR_RESET));
    send_fields(tss_pkg::KIND_CREATE, 0, 0, 0);
    send_fields(tss_pkg::KIND_SCHEDULE, 0, 0, 32'hFFFF_FFFF);
    send_fields(tss_pkg::KIND_CREATE, 3, 65535, 32'hFFFF_FFFF);
    send_fields(tss_pkg::KIND_SCHEDULE, 0, 0, 32'hFFFF_FFFF);
    send_fields(tss_pkg::KIND_EXIT, 0, 0, 0);
  endtask

  task automatic test_round_robin();
    configure(tss_pkg::MODE_RR, 24'd0);
    run_random(190);
  endtask

  task automatic test_priority_aging();
    configure(tss_pkg::MODE_PRIO, 24'd0);
    run_random(100);
    configure(tss_pkg::MODE_PRIO, 24'hFF_FFFF);
    run_random(100);
    configure(tss_pkg::MODE_PRIO, 24'd2000);
    run_random(130);
  endtask

  task automatic test_lottery();
    configure(tss_pkg::MODE_LOTTERY, 24'd1);
    run_random(220);
  endtask

  task automatic test_mode_three();
    configure(MODE_ALT_RR, 24'd500);
    run_random(130);
  endtask

  // Result side holds off while requests keep coming without gaps.
  task automatic test_backpressure();
    configure(tss_pkg::MODE_PRIO, 24'd5000);
    idle_on = 1'b0;
    run_random(40);
    hold_reqs++;
    run_random(60);
    idle_on = 1'b1;
    run_random(120);
    configure(tss_pkg::MODE_RR, tss_pkg::THR_W'(tss_pkg::THR_RESET));
    run_random(35);
  endtask

  initial begin
    errors    = 0;
    idle_on   = 1'b1;
    hold_reqs = 0;
    clock_us  = 48'hFFFF_FFFF_F000;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.kind  <= tss_pkg::KIND_CREATE;
    req.create_priority <= '0;
    req.create_tickets  <= '0;
    req.now_us          <= '0;
    req.random_value    <= '0;
    table_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_round_robin();
    test_priority_aging();
    test_lottery();
    test_mode_three();
    test_backpressure();

    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== thread_slot_scheduler.f =====
+incdir+hw/rtl
hw/rtl/tss_pkg.sv
hw/rtl/tss_req_if.sv
hw/rtl/tss_rsp_if.sv
hw/rtl/tss_ctrl.sv
hw/rtl/tss_dp.sv
hw/rtl/thread_slot_scheduler.sv
sim/tb_thread_slot_scheduler.sv
